// ===== src/fthq_pkg.sv =====
`default_nettype none
package fthq_pkg;

  localparam int NUM_TRIANGLES_DEFAULT = 2;
  localparam logic [7:0] FLOOR_BUFFER_RESET = 8'd78;

  localparam int COORD_W = 16;
  localparam int NORM_W = 18;
  localparam int OPND_W = 18;
  localparam int PROD_W = 2 * OPND_W;
  localparam int ACC_W = 38;
  localparam int DIVD_W = 46;
  localparam int DIVS_W = 18;
  localparam int HGT_W = 48;

  typedef enum logic [1:0] {
    MODE_VERTEX = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    OP_E1P, OP_E1N, OP_E2P, OP_E2N, OP_E3P, OP_E3N, OP_NX, OP_NY, OP_NZ
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_MSTART, S_MWAIT, S_DSTART, S_DWAIT, S_TEST, S_NEXT
  } state_t;

endpackage
`default_nettype wire

// ===== src/fthq_mul.sv =====
`default_nettype none
module fthq_mul (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [fthq_pkg::OPND_W-1:0]  a,
  input  wire logic signed [fthq_pkg::OPND_W-1:0]  b,
  output logic                                     done,
  output logic signed [fthq_pkg::PROD_W-1:0]       p
);

  localparam int W = fthq_pkg::OPND_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] ma;
  logic [2*W-1:0] prod;
  logic neg;
  logic [CW-1:0] cnt;
  logic [W:0] sum;

  assign sum = {1'b0, prod[2*W-1:W]} + (prod[0] ? {1'b0, ma} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt <= CW'(W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (cnt != '0) cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma <= a[W-1] ? W'(-a) : W'(a);
      prod <= {{W{1'b0}}, (b[W-1] ? W'(-b) : W'(b))};
      neg <= a[W-1] ^ b[W-1];
    end else if (cnt != '0) begin
      prod <= {sum, prod[W-1:1]};
    end
  end

  assign p = neg ? -$signed(prod) : $signed(prod);

endmodule
`default_nettype wire

// ===== src/fthq_div.sv =====
`default_nettype none
module fthq_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [fthq_pkg::DIVD_W-1:0]        dividend,
  input  wire logic [fthq_pkg::DIVS_W-1:0]        divisor,
  output logic                                    done,
  output logic [fthq_pkg::DIVD_W-1:0]             quotient
);

  localparam int N = fthq_pkg::DIVD_W;
  localparam int D = fthq_pkg::DIVS_W;
  localparam int CW = $clog2(N + 1);

  logic [D-1:0] dreg;
  logic [D-1:0] rem;
  logic [CW-1:0] cnt;
  logic [D:0] trial;

  assign trial = {rem, quotient[N-1]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt <= CW'(N);
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (cnt != '0) cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= divisor;
      rem <= '0;
      quotient <= dividend;
    end else if (cnt != '0) begin
      if (!trial[D]) begin
        rem <= trial[D-1:0];
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem <= {rem[D-2:0], quotient[N-1]};
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/floor_triangle_height_query.sv =====
`default_nettype none
// Floor height query over a small store of triangles. Load transactions write one vertex or
// one normal. A query transaction tries the triangles in slot order; each triangle takes a
// fetch step and up to nine products on a bit-serial 18 by 18 multiplier (fewer products
// when an edge test fails early or the normal's Y component is zero) and, when its edge
// tests pass and the normal's Y component is nonzero, a 46-step restoring divide and a
// test step for the plane height. Up to NUM_TRIANGLES triangles are examined per query.
// The result is written into an output register once that register is free, so a new
// transaction is taken while an earlier result waits there, and the query stalls only if
// the register is still occupied when its own result is ready.
module floor_triangle_height_query #(
  parameter int NUM_TRIANGLES = fthq_pkg::NUM_TRIANGLES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic               triangle_slot,
  input  wire logic [1:0]         vertex_slot,
  input  wire logic signed [17:0] value_a,
  input  wire logic signed [17:0] value_b,
  input  wire logic signed [17:0] value_c,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    found,
  output logic                    floor_index,
  output logic signed [31:0]      height
);

  localparam int TW = (NUM_TRIANGLES > 1) ? $clog2(NUM_TRIANGLES) : 1;
  localparam int CWD = fthq_pkg::COORD_W;
  localparam int NW = fthq_pkg::NORM_W;
  localparam int OW = fthq_pkg::OPND_W;
  localparam int AW = fthq_pkg::ACC_W;
  localparam int HW = fthq_pkg::HGT_W;
  localparam int DW = fthq_pkg::DIVS_W;

  logic signed [CWD-1:0] vx [NUM_TRIANGLES][3];
  logic signed [CWD-1:0] vy [NUM_TRIANGLES][3];
  logic signed [CWD-1:0] vz [NUM_TRIANGLES][3];
  logic signed [NW-1:0] nxs [NUM_TRIANGLES];
  logic signed [NW-1:0] nys [NUM_TRIANGLES];
  logic signed [NW-1:0] nzs [NUM_TRIANGLES];

  logic signed [CWD-1:0] x1, y1, z1, x2, z2, x3, z3, px, py, pz;
  logic signed [NW-1:0] nx, ny, nz;
  logic [7:0] floor_buffer;

  fthq_pkg::state_t state, state_next;
  fthq_pkg::op_t op;
  logic [TW-1:0] t;
  logic signed [AW-1:0] acc, acc_next;
  logic signed [HW-1:0] h;

  logic signed [OW-1:0] ma, mb;
  logic mul_start, mul_done, div_start, div_done;
  logic signed [fthq_pkg::PROD_W-1:0] p;
  logic [fthq_pkg::DIVD_W-1:0] q;
  logic [AW-1:0] acc_mag;
  logic [DW-1:0] ny_mag;
  logic signed [HW-1:0] h_new, diff;
  logic sub, in_go, slot_ok, last_t, sat_hi, sat_lo, out_free, result_go;
  logic signed [31:0] h_sat;

  function automatic logic signed [OW-1:0] dif(input logic signed [CWD-1:0] a,
                                                  input logic signed [CWD-1:0] b);
    dif = OW'(a) - OW'(b);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready = (state == fthq_pkg::S_IDLE);
  assign in_go = in_valid && in_ready;
  assign slot_ok = 32'(triangle_slot) < NUM_TRIANGLES;
  assign last_t = 32'(t) == NUM_TRIANGLES - 1;
  assign out_free = !out_valid || out_ready;
  assign result_go = out_free && ((state == fthq_pkg::S_TEST && !diff[HW-1]) ||
                                  (state == fthq_pkg::S_NEXT && last_t));

  always_comb begin
    sub = 1'b0;
    ma = dif(z1, pz);
    mb = dif(x2, x1);
    case (op)
      fthq_pkg::OP_E1P: begin ma = dif(z1, pz); mb = dif(x2, x1); end
      fthq_pkg::OP_E1N: begin ma = dif(x1, px); mb = dif(z2, z1); sub = 1'b1; end
      fthq_pkg::OP_E2P: begin ma = dif(z2, pz); mb = dif(x3, x2); end
      fthq_pkg::OP_E2N: begin ma = dif(x2, px); mb = dif(z3, z2); sub = 1'b1; end
      fthq_pkg::OP_E3P: begin ma = dif(z3, pz); mb = dif(x1, x3); end
      fthq_pkg::OP_E3N: begin ma = dif(x3, px); mb = dif(z1, z3); sub = 1'b1; end
      fthq_pkg::OP_NX:  begin ma = nx; mb = dif(x1, px); end
      fthq_pkg::OP_NY:  begin ma = ny; mb = OW'(y1); end
      fthq_pkg::OP_NZ:  begin ma = nz; mb = dif(z1, pz); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign acc_next = sub ? acc - AW'(p) : acc + AW'(p);
  assign acc_mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign ny_mag = ny[NW-1] ? DW'(-ny) : DW'(ny);
  assign h_new = (acc[AW-1] ^ ny[NW-1]) ? -$signed({2'b00, q}) : $signed({2'b00, q});
  assign diff = {{(HW-CWD-8){py[CWD-1]}}, py, 8'd0} - h
              + $signed({{(HW-16){1'b0}}, floor_buffer, 8'd0});
  assign sat_hi = !h[HW-1] && (h[HW-2:31] != '0);
  assign sat_lo = h[HW-1] && (h[HW-2:31] != '1);
  assign h_sat = sat_hi ? 32'sh7FFFFFFF : (sat_lo ? 32'sh80000000 : h[31:0]);

  fthq_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(ma), .b(mb), .done(mul_done), .p(p)
  );

  fthq_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend({acc_mag, 8'd0}),
    .divisor(ny_mag), .done(div_done), .quotient(q)
  );

  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      fthq_pkg::S_IDLE: begin
        if (in_go && mode == fthq_pkg::MODE_QUERY) state_next = fthq_pkg::S_FETCH;
      end
      fthq_pkg::S_FETCH: state_next = fthq_pkg::S_MSTART;
      fthq_pkg::S_MSTART: begin
        mul_start = 1'b1;
        state_next = fthq_pkg::S_MWAIT;
      end
      fthq_pkg::S_MWAIT: begin
        if (mul_done) begin
          if (op == fthq_pkg::OP_NZ) begin
            state_next = fthq_pkg::S_DSTART;
          end else if (sub && acc_next[AW-1]) begin
            state_next = fthq_pkg::S_NEXT;
          end else if (op == fthq_pkg::OP_E3N && ny == '0) begin
            state_next = fthq_pkg::S_NEXT;
          end else begin
            state_next = fthq_pkg::S_MSTART;
          end
        end
      end
      fthq_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_next = fthq_pkg::S_DWAIT;
      end
      fthq_pkg::S_DWAIT: if (div_done) state_next = fthq_pkg::S_TEST;
      fthq_pkg::S_TEST: begin
        if (!diff[HW-1]) begin
          if (out_free) state_next = fthq_pkg::S_IDLE;
        end else begin
          state_next = fthq_pkg::S_NEXT;
        end
      end
      fthq_pkg::S_NEXT: begin
        if (last_t) begin
          if (out_free) state_next = fthq_pkg::S_IDLE;
        end else begin
          state_next = fthq_pkg::S_FETCH;
        end
      end
      default: state_next = fthq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fthq_pkg::S_IDLE;
      floor_buffer <= fthq_pkg::FLOOR_BUFFER_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) floor_buffer <= cfg_data;
      if (result_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      if (mode == fthq_pkg::MODE_VERTEX && slot_ok && vertex_slot != 2'd3) begin
        vx[TW'(triangle_slot)][vertex_slot] <= value_a[CWD-1:0];
        vy[TW'(triangle_slot)][vertex_slot] <= value_b[CWD-1:0];
        vz[TW'(triangle_slot)][vertex_slot] <= value_c[CWD-1:0];
      end
      if (mode == fthq_pkg::MODE_NORMAL && slot_ok) begin
        nxs[TW'(triangle_slot)] <= value_a;
        nys[TW'(triangle_slot)] <= value_b;
        nzs[TW'(triangle_slot)] <= value_c;
      end
      px <= value_a[CWD-1:0];
      py <= value_b[CWD-1:0];
      pz <= value_c[CWD-1:0];
      t <= '0;
    end
    case (state)
      fthq_pkg::S_FETCH: begin
        x1 <= vx[t][0]; y1 <= vy[t][0]; z1 <= vz[t][0];
        x2 <= vx[t][1]; z2 <= vz[t][1];
        x3 <= vx[t][2]; z3 <= vz[t][2];
        nx <= nxs[t]; ny <= nys[t]; nz <= nzs[t];
        op <= fthq_pkg::OP_E1P;
        acc <= '0;
      end
      fthq_pkg::S_MWAIT: begin
        if (mul_done) begin
          acc <= (sub && op != fthq_pkg::OP_NZ) ? '0 : acc_next;
          if (op != fthq_pkg::OP_NZ) op <= fthq_pkg::op_t'(op + 4'd1);
        end
      end
      fthq_pkg::S_DWAIT: if (div_done) h <= h_new;
      fthq_pkg::S_TEST: begin
        if (!diff[HW-1] && out_free) begin
          found <= 1'b1;
          floor_index <= t[0];
          height <= h_sat;
        end
      end
      fthq_pkg::S_NEXT: begin
        if (last_t) begin
          if (out_free) begin
            found <= 1'b0;
            floor_index <= 1'b0;
            height <= '0;
          end
        end else begin
          t <= t + TW'(1);
        end
      end
      default: ;
    endcase
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> height == 32'sd0 && !floor_index)
    else $error("empty result carries nonzero fields");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == fthq_pkg::S_MWAIT)
    else $error("multiplier finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == fthq_pkg::S_DWAIT)
    else $error("divider finished outside its wait state");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(floor_index)
                                && $stable(height))
    else $error("waiting result changed before it was taken");

endmodule
`default_nettype wire
